FILE: design/dru_pkg.sv
// shared constants, item types and op codes for the dirty region updater
// no dependencies
package dru_pkg;

  localparam int FRAME_BYTES = 4096;
  localparam int MEM_BYTES   = 8192;
  localparam int FRAME_AW    = $clog2(FRAME_BYTES);
  localparam int MEM_AW      = $clog2(MEM_BYTES);

  localparam logic [7:0] HDR_STX       = 8'h02;
  localparam logic [7:0] HDR_SECOND    = 8'h44;
  localparam logic [7:0] CMD_BIT_IMAGE = 8'h46;
  localparam logic [3:0] HDR_LEN       = 4'd8;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PENDING = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  localparam logic [1:0] REG_DEVICE = 2'd0;
  localparam logic [1:0] REG_AREA   = 2'd1;
  localparam logic [1:0] REG_MEMORY = 2'd2;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_SETADR = 3'd1,
    OP_ROTATE = 3'd2,
    OP_SHOW   = 3'd3,
    OP_FULL   = 3'd4,
    OP_PULL   = 3'd5,
    OP_NOP    = 3'd6
  } dru_op_e;

  typedef struct packed {
    dru_op_e     op;
    logic [11:0] frame_index;
    logic [7:0]  pixel_byte;
    logic [12:0] draw_address;
  } dru_item_t;

endpackage

FILE: design/dru_if.sv
// channel interfaces: input items, result items, register writes
// no dependencies
interface dru_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [11:0] frame_index;
  logic [7:0]  pixel_byte;
  logic [12:0] draw_address;
  modport source(output valid, op, frame_index, pixel_byte, draw_address, input ready);
  modport sink(input valid, op, frame_index, pixel_byte, draw_address, output ready);
endinterface

interface dru_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  bus_byte;
  logic        byte_valid;
  logic        last_byte;
  logic        changed;
  logic [11:0] dirty_start;
  logic [12:0] dirty_size;
  modport source(output valid, status, bus_byte, byte_valid, last_byte, changed,
                 dirty_start, dirty_size, input ready);
  modport sink(input valid, status, bus_byte, byte_valid, last_byte, changed,
               dirty_start, dirty_size, output ready);
endinterface

interface dru_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: design/display_dirty_region_updater.sv
// Dirty region updater for a graphic display: keeps a frame buffer and a
// shadow of display memory, and hands out bit-image commands byte by byte.
// Channels: in_i (op and operands), out_o (one result per item), cfg_i
// (register writes: 0 device address, 1 area size, 2 memory size; writes
// while a transfer is pending are dropped).
// Every input item gives exactly one result item. Load, set address and
// header pulls register their result straight from the queue; a data pull
// passes a read and a write state; a rotate runs the remainder unit, one
// bit per cycle. A show (not the first one or a full show, which take the
// whole area) compares through the registered frame and shadow reads: a
// forward scan to the first difference, then a backward scan down to it.
// A two-entry queue sits between the front and the back, so input is taken
// while a result waits; when out_o stalls, the back holds its result and
// the queue fills, then in_i drops ready.
// Reset: both memories are cleared by a pass over the 8192 shadow entries,
// one per cycle; no item is executed in the pass (register writes are taken).
// depends on dru_pkg, dru_if, dru_front and dru_back
module display_dirty_region_updater (
  input  logic      clk_i,
  input  logic      rst_ni,
  dru_in_if.sink    in_i,
  dru_out_if.source out_o,
  dru_cfg_if.sink   cfg_i
);
  import dru_pkg::*;

  logic      q_valid;
  logic      q_ready;
  dru_item_t q_item;

  // accept and classify
  dru_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_ready_i (q_ready)
  );

  // execute
  dru_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_ready_o (q_ready),
    .cfg_i     (cfg_i),
    .out_o     (out_o)
  );

endmodule

FILE: design/dru_front.sv
// front part: accepts input items, classifies the op, two-entry queue to back
// depends on dru_pkg and dru_in_if
module dru_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  dru_in_if.sink             in_i,
  output logic               q_valid_o,
  output dru_pkg::dru_item_t q_item_o,
  input  logic               q_ready_i
);
  import dru_pkg::*;

  dru_item_t  mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  dru_item_t  item;

  // op classification, unused codes become no-ops
  always_comb begin
    item.frame_index  = in_i.frame_index;
    item.pixel_byte   = in_i.pixel_byte;
    item.draw_address = in_i.draw_address;
    case (in_i.op)
      3'd0:    item.op = OP_LOAD;
      3'd1:    item.op = OP_SETADR;
      3'd2:    item.op = OP_ROTATE;
      3'd3:    item.op = OP_SHOW;
      3'd4:    item.op = OP_FULL;
      3'd5:    item.op = OP_PULL;
      default: item.op = OP_NOP;
    endcase
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = mem_q[rd_q];

  // queue pointers
  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item;
    end
  end

  property p_no_push_when_full;
    @(posedge clk_i) disable iff (!rst_ni) (cnt_q == 2'd2) |-> !push;
  endproperty
  a_no_push_when_full: assert property (p_no_push_when_full)
    else $error("push into full queue");

  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3;
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("queue count overflow");

  property p_empty_ptrs;
    @(posedge clk_i) disable iff (!rst_ni) (cnt_q == 2'd0) |-> (wr_q == rd_q);
  endproperty
  a_empty_ptrs: assert property (p_empty_ptrs) else $error("queue pointers out of step");

endmodule

FILE: design/dru_back.sv
// back part: config registers, frame and shadow memories, show scan, bus bytes
// depends on dru_pkg, dru_out_if and dru_cfg_if
module dru_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  dru_pkg::dru_item_t q_item_i,
  output logic               q_ready_o,
  dru_cfg_if.sink            cfg_i,
  dru_out_if.source          out_o
);
  import dru_pkg::*;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_ROT     = 4'd2;
  localparam logic [3:0] S_FWD_RD  = 4'd3;
  localparam logic [3:0] S_FWD_CMP = 4'd4;
  localparam logic [3:0] S_BWD_RD  = 4'd5;
  localparam logic [3:0] S_BWD_CMP = 4'd6;
  localparam logic [3:0] S_PULL_RD = 4'd7;
  localparam logic [3:0] S_PULL_WR = 4'd8;

  logic [3:0]  state_q, state_d;
  logic [7:0]  dev_q;
  logic [12:0] area_q;
  logic [13:0] mem_sz_q;
  logic [12:0] da_q, da_d;
  logic        first_q, first_d;
  logic        act_q, act_d;
  logic [11:0] pstart_q, pstart_d;
  logic [12:0] psize_q, psize_d;
  logic [13:0] pos_q, pos_d;
  logic [12:0] idx_q, idx_d;
  logic [12:0] span_q, span_d;
  logic [11:0] fst_q, fst_d;
  logic [13:0] rem_q, rem_d;
  logic [13:0] dvd_q, dvd_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [MEM_AW:0] clr_q;

  logic        ov_q, ov_d;
  logic [1:0]  st_q, st_d;
  logic [7:0]  byte_q, byte_d;
  logic        bv_q, bv_d, lb_q, lb_d, ch_q, ch_d;
  logic [11:0] ds_q, ds_d;
  logic [12:0] dz_q, dz_d;

  logic [7:0]  frame_mem [FRAME_BYTES];
  logic [7:0]  shadow_mem [MEM_BYTES];
  logic [7:0]  fr_rd_q, sh_rd_q;
  logic [FRAME_AW-1:0] fr_ra, fr_wa;
  logic [MEM_AW-1:0]   sh_ra, sh_wa;
  logic        fr_we, sh_we;
  logic [7:0]  fr_wd, sh_wd;

  logic [12:0] area_eff;
  logic [13:0] mem_eff;
  logic [13:0] span_full;
  logic [13:0] rot_t;
  logic [15:0] addr_word;
  logic [13:0] si;
  logic        take;
  logic        clearing;

  // clamped registers
  always_comb begin
    if (area_q == 13'd0) area_eff = 13'd1;
    else if (area_q > 13'(FRAME_BYTES)) area_eff = 13'(FRAME_BYTES);
    else area_eff = area_q;
    if (mem_sz_q == 14'd0) mem_eff = 14'd1;
    else if (mem_sz_q > 14'(MEM_BYTES)) mem_eff = 14'(MEM_BYTES);
    else mem_eff = mem_sz_q;
  end

  assign clearing  = (state_q == S_CLEAR);
  assign q_ready_o = (state_q == S_IDLE) && !ov_q;
  assign take      = q_valid_i && q_ready_o;
  assign span_full = ({1'b0, da_q} >= mem_eff) ? 14'd0 : (mem_eff - {1'b0, da_q});
  assign rot_t     = {rem_q[12:0], dvd_q[13]};
  assign addr_word = {3'd0, da_q} + {4'd0, pstart_q};
  assign si        = {1'b0, da_q} + {2'd0, idx_q[11:0]};

  // register writes, taken only with no transfer pending
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q    <= 8'd0;
      area_q   <= 13'(FRAME_BYTES);
      mem_sz_q <= 14'(MEM_BYTES);
    end else if (cfg_i.valid && !act_q) begin
      case (cfg_i.index)
        REG_DEVICE: dev_q    <= cfg_i.data[7:0];
        REG_AREA:   area_q   <= cfg_i.data[12:0];
        REG_MEMORY: mem_sz_q <= cfg_i.data;
        default:    ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q; da_d = da_q; first_d = first_q; act_d = act_q;
    pstart_d = pstart_q; psize_d = psize_q; pos_d = pos_q; idx_d = idx_q;
    span_d = span_q; fst_d = fst_q; rem_d = rem_q; dvd_d = dvd_q; cnt_d = cnt_q;
    ov_d = ov_q && !out_o.ready;
    st_d = st_q; byte_d = byte_q; bv_d = bv_q; lb_d = lb_q; ch_d = ch_q;
    ds_d = ds_q; dz_d = dz_q;
    fr_ra = idx_q[FRAME_AW-1:0];
    sh_ra = si[MEM_AW-1:0];
    fr_we = 1'b0; fr_wa = q_item_i.frame_index; fr_wd = q_item_i.pixel_byte;
    sh_we = 1'b0; sh_wa = si[MEM_AW-1:0]; sh_wd = fr_rd_q;

    case (state_q)
      S_CLEAR: begin
        fr_we = clr_q < (MEM_AW+1)'(FRAME_BYTES);
        fr_wa = clr_q[FRAME_AW-1:0];
        fr_wd = 8'd0;
        sh_we = 1'b1;
        sh_wa = clr_q[MEM_AW-1:0];
        sh_wd = 8'd0;
        if (clr_q == (MEM_AW+1)'(MEM_BYTES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          st_d = ST_OK; byte_d = 8'd0; bv_d = 1'b0; lb_d = 1'b0; ch_d = 1'b0;
          ds_d = 12'd0; dz_d = 13'd0;
          ov_d = 1'b1;
          case (q_item_i.op)
            OP_LOAD: fr_we = 1'b1;
            OP_SETADR: begin
              if (act_q) st_d = ST_PENDING;
              else da_d = q_item_i.draw_address;
            end
            OP_ROTATE: begin
              if (act_q) st_d = ST_PENDING;
              else begin
                ov_d = 1'b0;
                rem_d = 14'd0;
                dvd_d = {1'b0, da_q} + {1'b0, area_eff};
                cnt_d = 4'd0;
                state_d = S_ROT;
              end
            end
            OP_SHOW, OP_FULL: begin
              if (act_q) st_d = ST_PENDING;
              else if (first_q || q_item_i.op == OP_FULL) begin
                first_d = 1'b0;
                ch_d = 1'b1; dz_d = area_eff;
                pstart_d = 12'd0; psize_d = area_eff;
                pos_d = 14'd0; act_d = 1'b1;
              end else if (span_full != 14'd0) begin
                ov_d = 1'b0;
                span_d = (span_full > {1'b0, area_eff}) ? area_eff : span_full[12:0];
                idx_d = 13'd0;
                state_d = S_FWD_RD;
              end
            end
            OP_PULL: begin
              if (!act_q) st_d = ST_EMPTY;
              else if (pos_q < {10'd0, HDR_LEN}) begin
                bv_d = 1'b1;
                pos_d = pos_q + 14'd1;
                case (pos_q[2:0])
                  3'd0:    byte_d = HDR_STX;
                  3'd1:    byte_d = HDR_SECOND;
                  3'd2:    byte_d = dev_q;
                  3'd3:    byte_d = CMD_BIT_IMAGE;
                  3'd4:    byte_d = addr_word[7:0];
                  3'd5:    byte_d = addr_word[15:8];
                  3'd6:    byte_d = psize_q[7:0];
                  default: byte_d = {3'd0, psize_q[12:8]};
                endcase
              end else begin
                ov_d = 1'b0;
                idx_d = {1'b0, pstart_q + pos_q[11:0] - 12'(HDR_LEN)};
                state_d = S_PULL_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_ROT: begin
        // one remainder bit per cycle
        rem_d = (rot_t >= mem_eff) ? (rot_t - mem_eff) : rot_t;
        dvd_d = {dvd_q[12:0], 1'b0};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd13) begin
          da_d = rem_d[12:0];
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FWD_RD: state_d = S_FWD_CMP;
      S_FWD_CMP: begin
        if (fr_rd_q != sh_rd_q) begin
          fst_d = idx_q[11:0];
          if (idx_q == span_q - 13'd1) begin
            ch_d = 1'b1; ds_d = idx_q[11:0]; dz_d = 13'd1;
            pstart_d = idx_q[11:0]; psize_d = 13'd1;
            pos_d = 14'd0; act_d = 1'b1; ov_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            idx_d = span_q - 13'd1;
            state_d = S_BWD_RD;
          end
        end else if (idx_q + 13'd1 == span_q) begin
          ov_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 13'd1;
          state_d = S_FWD_RD;
        end
      end
      S_BWD_RD: state_d = S_BWD_CMP;
      S_BWD_CMP: begin
        if (fr_rd_q != sh_rd_q || idx_q - 13'd1 == {1'b0, fst_q}) begin
          if (fr_rd_q != sh_rd_q) dz_d = idx_q - {1'b0, fst_q} + 13'd1;
          else dz_d = 13'd1;
          psize_d = dz_d;
          ch_d = 1'b1; ds_d = fst_q; pstart_d = fst_q;
          pos_d = 14'd0; act_d = 1'b1; ov_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q - 13'd1;
          state_d = S_BWD_RD;
        end
      end
      S_PULL_RD: state_d = S_PULL_WR;
      S_PULL_WR: begin
        // data byte leaves, shadow follows when inside display memory
        sh_we = si < mem_eff;
        byte_d = fr_rd_q;
        bv_d = 1'b1;
        pos_d = pos_q + 14'd1;
        if (pos_d >= {10'd0, HDR_LEN} + {1'b0, psize_q}) begin
          lb_d = 1'b1; act_d = 1'b0; pos_d = 14'd0;
        end
        ov_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      da_q    <= 13'd0;
      first_q <= 1'b1;
      act_q   <= 1'b0;
      pos_q   <= 14'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clearing ? clr_q + 1'b1 : clr_q;
      da_q    <= da_d;
      first_q <= first_d;
      act_q   <= act_d;
      pos_q   <= pos_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pstart_q <= pstart_d; psize_q <= psize_d; idx_q <= idx_d; span_q <= span_d;
    fst_q <= fst_d; rem_q <= rem_d; dvd_q <= dvd_d; cnt_q <= cnt_d;
    st_q <= st_d; byte_q <= byte_d; bv_q <= bv_d; lb_q <= lb_d; ch_q <= ch_d;
    ds_q <= ds_d; dz_q <= dz_d;
  end

  // frame memory
  always_ff @(posedge clk_i) begin
    if (fr_we) frame_mem[fr_wa] <= fr_wd;
    fr_rd_q <= frame_mem[fr_ra];
  end

  // shadow memory
  always_ff @(posedge clk_i) begin
    if (sh_we) shadow_mem[sh_wa] <= sh_wd;
    sh_rd_q <= shadow_mem[sh_ra];
  end

  assign out_o.valid       = ov_q;
  assign out_o.status      = st_q;
  assign out_o.bus_byte    = byte_q;
  assign out_o.byte_valid  = bv_q;
  assign out_o.last_byte   = lb_q;
  assign out_o.changed     = ch_q;
  assign out_o.dirty_start = ds_q;
  assign out_o.dirty_size  = dz_q;

  property p_last_has_byte;
    @(posedge clk_i) disable iff (!rst_ni) (ov_q && lb_q) |-> (bv_q && !act_q);
  endproperty
  a_last_has_byte: assert property (p_last_has_byte) else $error("last byte without byte");

  property p_changed_sets_active;
    @(posedge clk_i) disable iff (!rst_ni) (ov_q && ch_q) |-> (act_q && dz_q != 13'd0);
  endproperty
  a_changed_sets_active: assert property (p_changed_sets_active)
    else $error("show result without pending transfer");

  property p_pos_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      act_q |-> (pos_q < {10'd0, HDR_LEN} + {1'b0, psize_q});
  endproperty
  a_pos_bound: assert property (p_pos_bound) else $error("emit position past command end");

  property p_no_result_clearing;
    @(posedge clk_i) disable iff (!rst_ni) clearing |-> (!ov_q && !q_ready_o);
  endproperty
  a_no_result_clearing: assert property (p_no_result_clearing)
    else $error("activity during clearing pass");

endmodule
